// ===== rtl/vbs_pkg.sv =====
// Package for the ViBe background subtractor: sizes, constants, register
// indexes, divider request/response types and neighbour helpers.
// No dependencies.
package vbs_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int PIX_DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int PIX_AW      = $clog2(PIX_DEPTH);
  localparam int SLOT_W      = $clog2(MAX_SAMPLES);
  localparam int SAMPLE_AW   = SLOT_W + PIX_AW;
  localparam int SAMPLE_DEPTH = MAX_SAMPLES * PIX_DEPTH;

  localparam logic [31:0] MWC_MULT = 32'd4164903690;
  localparam logic [7:0]  FG_LIMIT = 8'd50;
  localparam logic [7:0]  NB_COUNT = 8'd9;

  localparam logic [2:0] REG_SAMP_COUNT  = 3'd0;
  localparam logic [2:0] REG_MATCH_NEED  = 3'd1;
  localparam logic [2:0] REG_RADIUS      = 3'd2;
  localparam logic [2:0] REG_SUBSAMPLE   = 3'd3;
  localparam logic [2:0] REG_FRAME_ROWS  = 3'd4;
  localparam logic [2:0] REG_FRAME_COLS  = 3'd5;
  localparam logic [2:0] REG_SEED        = 3'd6;

  localparam logic [4:0]  RST_SAMP_COUNT  = 5'd16;
  localparam logic [4:0]  RST_MATCH_NEED  = 5'd2;
  localparam logic [8:0]  RST_RADIUS      = 9'd20;
  localparam logic [7:0]  RST_SUBSAMPLE   = 8'd16;
  localparam logic [6:0]  RST_FRAME_ROWS  = 7'd64;
  localparam logic [6:0]  RST_FRAME_COLS  = 7'd64;
  localparam logic [63:0] RST_SEED        = 64'd4294967295;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [7:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } mod_rsp_t;

  // neighbour index k -> row offset k/3
  function automatic logic [1:0] nb_row(input logic [3:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // neighbour index k -> column offset k%3
  function automatic logic [1:0] nb_col(input logic [3:0] k);
    logic [1:0] c;
    case (k)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/vbs_pixel_if.sv =====
// Pixel channel: valid/ready handshake with the 3x3 neighbourhood payload.
// Depends on nothing.
interface vbs_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_nw;
  logic [7:0] pix_n;
  logic [7:0] pix_ne;
  logic [7:0] pix_w;
  logic [7:0] pix_c;
  logic [7:0] pix_e;
  logic [7:0] pix_sw;
  logic [7:0] pix_s;
  logic [7:0] pix_se;
  logic [5:0] pix_row;
  logic [5:0] pix_col;
  logic       restart;

  modport source (output valid, pix_nw, pix_n, pix_ne, pix_w, pix_c, pix_e,
                  pix_sw, pix_s, pix_se, pix_row, pix_col, restart,
                  input ready);
  modport sink (input valid, pix_nw, pix_n, pix_ne, pix_w, pix_c, pix_e,
                pix_sw, pix_s, pix_se, pix_row, pix_col, restart,
                output ready);
endinterface

// ===== rtl/vbs_result_if.sv =====
// Result channel: valid/ready handshake with the classification payload.
// Depends on nothing.
interface vbs_result_if;
  logic valid;
  logic ready;
  logic foreground;
  logic learning;

  modport source (output valid, foreground, learning, input ready);
  modport sink (input valid, foreground, learning, output ready);
endinterface

// ===== rtl/vbs_mod_unit.sv =====
// Iterative remainder unit: 32-bit dividend modulo 8-bit divisor,
// four quotient bits per cycle. Depends on vbs_pkg.
module vbs_mod_unit
  import vbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic [31:0] dvd;
  logic [7:0]  dv;
  logic [7:0]  rem;
  logic [7:0]  rem_next;
  logic [2:0]  cnt;
  logic        busy;
  logic        done;

  always_comb begin
    logic [8:0] t;
    t = {1'b0, rem};
    for (int i = 0; i < 4; i++) begin
      t = {t[7:0], dvd[31 - i]};
      if (t >= {1'b0, dv}) begin
        t = t - {1'b0, dv};
      end
    end
    rem_next = t[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 3'd7);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dv  <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[27:0], 4'b0};
      rem <= rem_next;
    end
  end

  assign rsp = '{done: done, rem: rem};

endmodule

// ===== rtl/vibe_background_subtractor.sv =====
// ViBe background subtractor top level: sample and counter memories,
// item sequencer, generator and APB register file.
// Depends on vbs_pkg, vbs_pixel_if, vbs_result_if, vbs_mod_unit.
//
//   port     dir   kind        payload
//   pixel    in    valid/rdy   3x3 gray values, row, col, restart
//   result   out   valid/rdy   foreground, learning
//   apb      in    psel/pen    7 registers at 8*i, 64-bit data
//
// Reset starts a pass that zeroes the counter memory; no pixel is taken
// until it ends. Each random draw runs through a generator step, the
// divider start, the wait on the remainder unit and the write-back.
// Learning: one draw per sample. Classification: accept, scan, decide,
// result, plus up to five draws. One item at a time; the next is taken
// while the result waits, and an item's result stalls in the last state
// until the previous one has been taken.
module vibe_background_subtractor
  import vbs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  vbs_pixel_if.sink     pixel,
  vbs_result_if.source  result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_SCAN   = 4'd2;
  localparam logic [3:0] ST_DECIDE = 4'd3;
  localparam logic [3:0] ST_DRAW   = 4'd4;
  localparam logic [3:0] ST_MSTART = 4'd5;
  localparam logic [3:0] ST_MWAIT  = 4'd6;
  localparam logic [3:0] ST_APPLY  = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  localparam logic [2:0] OP_LEARN    = 3'd0;
  localparam logic [2:0] OP_OWN_TEST = 3'd1;
  localparam logic [2:0] OP_OWN_SLOT = 3'd2;
  localparam logic [2:0] OP_NB_TEST  = 3'd3;
  localparam logic [2:0] OP_NB_PICK  = 3'd4;
  localparam logic [2:0] OP_NB_SLOT  = 3'd5;
  localparam logic [2:0] OP_FG_TEST  = 3'd6;
  localparam logic [2:0] OP_FG_SLOT  = 3'd7;

  // registers
  logic [4:0]  samp_count;
  logic [4:0]  match_need;
  logic [8:0]  radius;
  logic [7:0]  upd_factor;
  logic [6:0]  frame_rows;
  logic [6:0]  frame_cols;
  logic [63:0] random_seed;
  logic [63:0] prng;
  logic        learn_mode;

  logic [3:0]        state;
  logic [2:0]        op;
  logic [PIX_AW-1:0] clr;
  logic [7:0]        nb [0:8];
  logic [5:0]        row;
  logic [5:0]        col;
  logic [PIX_AW-1:0] addr;
  logic [PIX_AW-1:0] na;
  logic [4:0]        k;
  logic              pend;
  logic [4:0]        hits;
  logic              bg;
  logic              res_fg;
  logic              res_learn;
  logic              out_valid;
  logic              out_fg;
  logic              out_learn;

  logic [7:0] sample_mem [0:SAMPLE_DEPTH-1];
  logic [7:0] fg_mem [0:PIX_DEPTH-1];
  logic [7:0] s_rdata;
  logic [7:0] fg_rdata;

  logic                 s_we;
  logic [SAMPLE_AW-1:0] s_waddr;
  logic [7:0]           s_wdata;
  logic                 fg_we;
  logic [PIX_AW-1:0]    fg_waddr;
  logic [7:0]           fg_wdata;

  logic [4:0]        ns_eff;
  logic [4:0]        need;
  logic [7:0]        sf_eff;
  logic [12:0]       rc_prod;
  logic [PIX_AW-1:0] addr_calc;
  logic [PIX_AW-1:0] na_calc;
  logic [PIX_AW-1:0] cols_w;
  logic [PIX_AW-1:0] row_term;
  logic [63:0]       mwc_prod;
  logic [63:0]       prng_next;
  logic [7:0]        diff;
  logic              hit;
  logic              bg_calc;
  logic [7:0]        cnt_inc;
  logic [3:0]        slot;
  logic              cfg_wr;
  logic              accept;
  logic [7:0]        mod_dv;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  vbs_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  assign ns_eff = (samp_count == 5'd0) ? 5'd1 :
                  (samp_count > 5'(MAX_SAMPLES)) ? 5'(MAX_SAMPLES) : samp_count;
  assign need   = (match_need == 5'd0) ? 5'd1 : match_need;
  assign sf_eff = (upd_factor == 8'd0) ? 8'd1 : upd_factor;

  assign rc_prod   = pixel.pix_row * frame_cols;
  assign addr_calc = rc_prod[PIX_AW-1:0] + PIX_AW'(pixel.pix_col);

  assign mwc_prod  = prng[31:0] * MWC_MULT;
  assign prng_next = mwc_prod + {32'b0, prng[63:32]};

  assign diff    = (s_rdata > nb[4]) ? (s_rdata - nb[4]) : (nb[4] - s_rdata);
  assign hit     = {1'b0, diff} < radius;
  assign bg_calc = hits >= need;
  assign cnt_inc = fg_rdata + 8'd1;
  assign slot    = mod_rsp.rem[3:0];

  assign cols_w = PIX_AW'(frame_cols);
  always_comb begin
    case (nb_row(slot))
      2'd0:    row_term = '0;
      2'd1:    row_term = cols_w;
      default: row_term = cols_w << 1;
    endcase
  end
  assign na_calc = addr + row_term + PIX_AW'(nb_col(slot)) - cols_w - PIX_AW'(1);

  assign accept = pixel.valid && pixel.ready;
  assign pixel.ready = (state == ST_IDLE);

  always_comb begin
    case (op)
      OP_LEARN, OP_NB_PICK:                 mod_dv = NB_COUNT;
      OP_OWN_TEST, OP_NB_TEST, OP_FG_TEST:  mod_dv = sf_eff;
      default:                              mod_dv = {3'b0, ns_eff};
    endcase
  end
  assign mod_req = '{start: (state == ST_MSTART), dividend: prng[31:0], divisor: mod_dv};

  // sample memory write port
  always_comb begin
    s_we    = 1'b0;
    s_waddr = {k[SLOT_W-1:0], addr};
    s_wdata = nb[4];
    if (state == ST_APPLY) begin
      case (op)
        OP_LEARN: begin
          s_we    = 1'b1;
          s_wdata = nb[slot];
        end
        OP_OWN_SLOT, OP_FG_SLOT: begin
          s_we    = 1'b1;
          s_waddr = {slot, addr};
        end
        OP_NB_SLOT: begin
          s_we    = 1'b1;
          s_waddr = {slot, na};
        end
        default: s_we = 1'b0;
      endcase
    end
  end

  assign fg_we    = (state == ST_CLEAR) || (state == ST_DECIDE);
  assign fg_waddr = (state == ST_CLEAR) ? clr : addr;
  assign fg_wdata = ((state == ST_CLEAR) || bg_calc) ? 8'd0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (s_we) begin
      sample_mem[s_waddr] <= s_wdata;
    end
    s_rdata <= sample_mem[{k[SLOT_W-1:0], addr}];
  end

  always_ff @(posedge clk) begin
    if (fg_we) begin
      fg_mem[fg_waddr] <= fg_wdata;
    end
    fg_rdata <= fg_mem[addr];
  end

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[5:3])
      REG_SAMP_COUNT:  prdata = 64'(samp_count);
      REG_MATCH_NEED:  prdata = 64'(match_need);
      REG_RADIUS:      prdata = 64'(radius);
      REG_SUBSAMPLE:   prdata = 64'(upd_factor);
      REG_FRAME_ROWS:  prdata = 64'(frame_rows);
      REG_FRAME_COLS:  prdata = 64'(frame_cols);
      REG_SEED:        prdata = random_seed;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samp_count  <= RST_SAMP_COUNT;
      match_need  <= RST_MATCH_NEED;
      radius      <= RST_RADIUS;
      upd_factor  <= RST_SUBSAMPLE;
      frame_rows  <= RST_FRAME_ROWS;
      frame_cols  <= RST_FRAME_COLS;
      random_seed <= RST_SEED;
      prng        <= RST_SEED;
    end else begin
      if (state == ST_DRAW) begin
        prng <= prng_next;
      end
      if (cfg_wr) begin
        case (paddr[5:3])
          REG_SAMP_COUNT:  samp_count <= pwdata[4:0];
          REG_MATCH_NEED:  match_need <= pwdata[4:0];
          REG_RADIUS:      radius     <= pwdata[8:0];
          REG_SUBSAMPLE:   upd_factor <= pwdata[7:0];
          REG_FRAME_ROWS:  frame_rows <= pwdata[6:0];
          REG_FRAME_COLS:  frame_cols <= pwdata[6:0];
          REG_SEED: begin
            random_seed <= pwdata;
            prng        <= pwdata;
          end
          default: ;
        endcase
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr        <= '0;
      learn_mode <= 1'b1;
      op         <= OP_LEARN;
      k          <= '0;
      pend       <= 1'b0;
      hits       <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr <= clr + PIX_AW'(1);
          if (clr == PIX_AW'(PIX_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            k    <= '0;
            pend <= 1'b0;
            hits <= '0;
            if (learn_mode || pixel.restart) begin
              learn_mode <= 1'b1;
              op         <= OP_LEARN;
              state      <= ST_DRAW;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (pend && hit) begin
            hits <= hits + 5'd1;
          end
          if (k < ns_eff) begin
            k    <= k + 5'd1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          bg        <= bg_calc;
          res_fg    <= !bg_calc;
          res_learn <= 1'b0;
          if (bg_calc) begin
            op    <= OP_OWN_TEST;
            state <= ST_DRAW;
          end else if (cnt_inc > FG_LIMIT) begin
            op    <= OP_FG_TEST;
            state <= ST_DRAW;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DRAW:   state <= ST_MSTART;
        ST_MSTART: state <= ST_MWAIT;
        ST_MWAIT: begin
          if (mod_rsp.done) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          state <= ST_DRAW;
          case (op)
            OP_LEARN: begin
              if (k + 5'd1 == ns_eff) begin
                res_fg    <= 1'b0;
                res_learn <= 1'b1;
                if (({1'b0, row} + 7'd2 == frame_rows) &&
                    ({1'b0, col} + 7'd2 == frame_cols)) begin
                  learn_mode <= 1'b0;
                end
                state <= ST_DONE;
              end else begin
                k <= k + 5'd1;
              end
            end
            OP_OWN_TEST: op <= (mod_rsp.rem == 8'd0) ? OP_OWN_SLOT : OP_NB_TEST;
            OP_OWN_SLOT: op <= OP_NB_TEST;
            OP_NB_TEST: begin
              if (mod_rsp.rem == 8'd0) begin
                op <= OP_NB_PICK;
              end else begin
                state <= ST_DONE;
              end
            end
            OP_NB_PICK: begin
              na <= na_calc;
              op <= OP_NB_SLOT;
            end
            OP_FG_TEST: begin
              if (mod_rsp.rem == 8'd0) begin
                op <= OP_FG_SLOT;
              end else begin
                state <= ST_DONE;
              end
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_DONE: begin
          if (!out_valid || result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || result.ready)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nb[0] <= pixel.pix_nw;
      nb[1] <= pixel.pix_n;
      nb[2] <= pixel.pix_ne;
      nb[3] <= pixel.pix_w;
      nb[4] <= pixel.pix_c;
      nb[5] <= pixel.pix_e;
      nb[6] <= pixel.pix_sw;
      nb[7] <= pixel.pix_s;
      nb[8] <= pixel.pix_se;
      row   <= pixel.pix_row;
      col   <= pixel.pix_col;
      addr  <= addr_calc;
    end
    if (state == ST_DONE && (!out_valid || result.ready)) begin
      out_fg    <= res_fg;
      out_learn <= res_learn;
    end
  end

  assign result.valid      = out_valid;
  assign result.foreground = out_fg;
  assign result.learning   = out_learn;

  a_learn_not_fg: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.learning |-> !result.foreground)
    else $error("learning result flagged foreground");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside completion");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && k == ns_eff && !pend |=> state == ST_DECIDE)
    else $error("scan did not end after last sample");

  a_hits_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECIDE |-> hits <= ns_eff)
    else $error("more matches than samples");

  a_bg_no_fg: assert property (@(posedge clk) disable iff (rst)
    state == ST_APPLY && (op == OP_NB_PICK || op == OP_OWN_SLOT) |-> bg)
    else $error("neighbour update on foreground pixel");

endmodule

// ===== tb/vbs_checker.sv =====
// Checker for the ViBe background subtractor: follows APB writes, predicts the
// result of every pixel transfer and compares it with the result transfers.
// Depends on vbs_pkg, vbs_pixel_if, vbs_result_if.
module vbs_checker
  import vbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  vbs_pixel_if        pixel,
  vbs_result_if       result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int          errors,
  output int          pending,
  output int          n_learn,
  output int          n_fg,
  output int          n_bg
);

  typedef struct packed {
    logic fg;
    logic learn;
  } class_t;

  logic [7:0]  samples [0:SAMPLE_DEPTH-1];
  logic [7:0]  fg_count [0:PIX_DEPTH-1];
  logic        learn_on;
  logic [63:0] mwc_state;
  logic [4:0]  cfg_ns;
  logic [4:0]  cfg_mm;
  logic [8:0]  cfg_radius;
  logic [7:0]  cfg_sf;
  logic [6:0]  cfg_rows;
  logic [6:0]  cfg_cols;
  class_t      class_q[$];

  function automatic logic [31:0] mwc_draw();
    mwc_state = {32'd0, mwc_state[31:0]} * {32'd0, MWC_MULT} + (mwc_state >> 32);
    return mwc_state[31:0];
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    case (idx)
      REG_SAMP_COUNT:  cfg_ns = v[4:0];
      REG_MATCH_NEED:  cfg_mm = v[4:0];
      REG_RADIUS:      cfg_radius = v[8:0];
      REG_SUBSAMPLE:   cfg_sf = v[7:0];
      REG_FRAME_ROWS:  cfg_rows = v[6:0];
      REG_FRAME_COLS:  cfg_cols = v[6:0];
      REG_SEED:        mwc_state = v;
      default: ;
    endcase
  endtask

  function automatic class_t classify_pixel(input logic [71:0] nbv, input logic [5:0] row,
                                            input logic [5:0] col, input logic restart);
    class_t      r;
    int unsigned ns, sf, need, hits, base, addr, na, slot, d;
    logic [7:0]  c, s;
    ns = (cfg_ns == 0) ? 1 : (cfg_ns > MAX_SAMPLES ? MAX_SAMPLES : cfg_ns);
    sf = (cfg_sf == 0) ? 1 : cfg_sf;
    need = (cfg_mm == 0) ? 1 : cfg_mm;
    base = row * cfg_cols + col;
    addr = base % PIX_DEPTH;
    c = nbv[4*8 +: 8];
    if (restart) learn_on = 1'b1;
    if (learn_on) begin
      for (int k = 0; k < ns; k++) begin
        slot = mwc_draw() % NB_COUNT;
        samples[k * PIX_DEPTH + addr] = nbv[slot*8 +: 8];
      end
      if (row + 2 == cfg_rows && col + 2 == cfg_cols) learn_on = 1'b0;
      r.fg = 1'b0;
      r.learn = 1'b1;
      return r;
    end
    hits = 0;
    for (int k = 0; k < ns; k++) begin
      s = samples[k * PIX_DEPTH + addr];
      d = (s > c) ? s - c : c - s;
      if (d < cfg_radius) hits++;
    end
    if (hits >= need) begin
      fg_count[addr] = 8'd0;
      if (mwc_draw() % sf == 0) begin
        slot = mwc_draw() % ns;
        samples[slot * PIX_DEPTH + addr] = c;
      end
      if (mwc_draw() % sf == 0) begin
        d = mwc_draw() % NB_COUNT;
        na = (base + (d / 3) * cfg_cols + (d % 3) - cfg_cols - 1) % PIX_DEPTH;
        slot = mwc_draw() % ns;
        samples[slot * PIX_DEPTH + na] = c;
      end
      r.fg = 1'b0;
    end else begin
      fg_count[addr] = fg_count[addr] + 8'd1;
      if (fg_count[addr] > FG_LIMIT && mwc_draw() % sf == 0) begin
        slot = mwc_draw() % ns;
        samples[slot * PIX_DEPTH + addr] = c;
      end
      r.fg = 1'b1;
    end
    r.learn = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    class_t want;
    if (rst) begin
      for (int i = 0; i < PIX_DEPTH; i++) fg_count[i] = 8'd0;
      learn_on = 1'b1;
      mwc_state = RST_SEED;
      cfg_ns = RST_SAMP_COUNT;
      cfg_mm = RST_MATCH_NEED;
      cfg_radius = RST_RADIUS;
      cfg_sf = RST_SUBSAMPLE;
      cfg_rows = RST_FRAME_ROWS;
      cfg_cols = RST_FRAME_COLS;
      class_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0)
        write_reg(paddr[5:3], pwdata);
      if (result.valid && result.ready) begin
        if (class_q.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = class_q.pop_front();
          if (result.foreground !== want.fg)
            report($sformatf("foreground %b, expected %b", result.foreground, want.fg));
          if (result.learning !== want.learn)
            report($sformatf("learning %b, expected %b", result.learning, want.learn));
          if (want.learn) n_learn++;
          else if (want.fg) n_fg++;
          else n_bg++;
        end
      end
      if (pixel.valid && pixel.ready)
        class_q.insert(class_q.size(),
                       classify_pixel({pixel.pix_se, pixel.pix_s, pixel.pix_sw,
                                       pixel.pix_e, pixel.pix_c, pixel.pix_w,
                                       pixel.pix_ne, pixel.pix_n, pixel.pix_nw},
                                      pixel.pix_row, pixel.pix_col, pixel.restart));
    end
    pending <= class_q.size();
  end

  initial begin
    errors = 0;
    n_learn = 0;
    n_fg = 0;
    n_bg = 0;
  end

endmodule

// ===== tb/vibe_background_subtractor_test.sv =====
// Top of the background subtractor testbench: clock, reset, APB setup, pixel
// stimulus in learning and classification phases, result stalls, verdict.
// Depends on vbs_pkg, vbs_pixel_if, vbs_result_if, vbs_checker and the block.
module vibe_background_subtractor_test;
  import vbs_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [5:0] row;
    logic [5:0] col;
    int         gray;
  } spot_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          errors, pending, n_learn, n_fg, n_bg;
  int          items = 0;
  int          phases = 0;
  bit          calm = 0;
  int          shadow_rows = int'(RST_FRAME_ROWS);
  int          shadow_cols = int'(RST_FRAME_COLS);
  spot_t       spots[$];

  vbs_pixel_if  px();
  vbs_result_if rs();

  vibe_background_subtractor dut (
    .clk(clk), .rst(rst), .pixel(px), .result(rs),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  vbs_checker chk (
    .clk(clk), .rst(rst), .pixel(px), .result(rs),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending),
    .n_learn(n_learn), .n_fg(n_fg), .n_bg(n_bg)
  );

  always #1 clk = ~clk;

  initial begin
    px.valid = 1'b0;
    {px.pix_nw, px.pix_n, px.pix_ne, px.pix_w, px.pix_c} = '0;
    {px.pix_e, px.pix_sw, px.pix_s, px.pix_se} = '0;
    px.pix_row = '0;
    px.pix_col = '0;
    px.restart = 1'b0;
    rs.ready = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] clamp8(input int v);
    return (v < 0) ? 8'd0 : (v > 255 ? 8'd255 : v[7:0]);
  endfunction

  // result side back-pressure
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = $urandom_range(1, 30);
      repeat (n) begin
        @(posedge clk);
        rs.ready <= 1'b1;
      end
      n = gap_len();
      repeat (n) begin
        @(posedge clk);
        rs.ready <= 1'b0;
      end
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'd0};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // the block is busy for many cycles after a transfer, so valid drops in time
  task automatic wait_idle();
    @(posedge clk);
    px.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_px(input logic [71:0] nbv, input logic [5:0] row,
                         input logic [5:0] col, input logic restart);
    int g;
    g = gap_len();
    if (g > 0) begin
      px.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    px.valid <= 1'b1;
    {px.pix_se, px.pix_s, px.pix_sw, px.pix_e, px.pix_c,
     px.pix_w, px.pix_ne, px.pix_n, px.pix_nw} <= nbv;
    px.pix_row <= row;
    px.pix_col <= col;
    px.restart <= restart;
    do @(posedge clk); while (!px.ready);
    items++;
  endtask

  // learning transfer; fixv >= 0 makes a flat neighbourhood of that gray
  task automatic learn_at(input logic [5:0] row, input logic [5:0] col,
                          input logic restart, input int fixv);
    logic [71:0] nbv;
    int          b;
    bit          noisy;
    spot_t       s;
    b = $urandom_range(0, 255);
    noisy = ($urandom_range(0, 99) < 15);
    for (int k = 0; k < 9; k++) begin
      if (fixv >= 0) nbv[k*8 +: 8] = 8'(fixv);
      else if (noisy) nbv[k*8 +: 8] = 8'($urandom_range(0, 255));
      else nbv[k*8 +: 8] = clamp8(b + $urandom_range(0, 12) - 6);
    end
    s.row = row;
    s.col = col;
    s.gray = int'(nbv[4*8 +: 8]);
    spots.insert(spots.size(), s);
    send_px(nbv, row, col, restart);
  endtask

  task automatic classify_one(input int fixc);
    spot_t       s;
    logic [71:0] nbv;
    s = spots[$urandom_range(0, spots.size() - 1)];
    for (int k = 0; k < 9; k++) nbv[k*8 +: 8] = 8'($urandom_range(0, 255));
    if (fixc >= 0) nbv[4*8 +: 8] = 8'(fixc);
    else if ($urandom_range(0, 99) < 75) nbv[4*8 +: 8] = clamp8(s.gray + $urandom_range(0, 20) - 10);
    send_px(nbv, s.row, s.col, 1'b0);
  endtask

  task automatic set_config(input int ns, input int mm, input int rad, input int sf,
                            input int rows, input int cols, input logic [63:0] seed);
    wait_idle();
    apb_write(REG_SAMP_COUNT, 64'(ns));
    apb_write(REG_MATCH_NEED, 64'(mm));
    apb_write(REG_RADIUS, 64'(rad));
    apb_write(REG_SUBSAMPLE, 64'(sf));
    apb_write(REG_FRAME_ROWS, 64'(rows));
    apb_write(REG_FRAME_COLS, 64'(cols));
    apb_write(REG_SEED, seed);
    shadow_rows = rows;
    shadow_cols = cols;
    spots.delete();
    phases++;
    calm = ($urandom_range(0, 3) == 0);
  endtask

  // learn n_pos spots, then optionally end learning and classify n_cls
  task automatic run_phase(input int n_pos, input int n_cls, input bit finish_learn);
    int r, c;
    for (int i = 0; i < n_pos; i++) begin
      do begin
        if ($urandom_range(0, 99) < 20 || shadow_rows < 3 || shadow_cols < 3) begin
          r = $urandom_range(0, 63);
          c = $urandom_range(0, 63);
        end else begin
          r = $urandom_range(1, shadow_rows - 2);
          c = $urandom_range(1, shadow_cols - 2);
        end
      end while (r == shadow_rows - 2 && c == shadow_cols - 2);
      learn_at(6'(r), 6'(c), i == 0 || $urandom_range(0, 9) == 0, -1);
    end
    if (finish_learn) begin
      learn_at(6'(shadow_rows - 2), 6'(shadow_cols - 2), n_pos == 0, -1);
      for (int i = 0; i < n_cls; i++) classify_one(-1);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, flat neighbourhoods, restart while learning
    set_config(16, 2, 20, 16, 64, 64, RST_SEED);
    apb_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    learn_at(6'd1, 6'd1, 1'b1, 0);
    learn_at(6'd0, 6'd0, 1'b0, 255);
    learn_at(6'd63, 6'd63, 1'b1, -1);
    learn_at(6'd0, 6'd63, 1'b0, -1);
    learn_at(6'd63, 6'd0, 1'b0, 128);
    learn_at(6'd62, 6'd62, 1'b0, -1);
    classify_one(0);
    classify_one(255);
    for (int i = 0; i < 8; i++) classify_one(-1);

    // no match possible: counter passes the update limit and wraps
    set_config(0, 0, 0, 0, 3, 3, 64'h0);
    run_phase(0, 270, 1'b1);

    // frame never ends learning; addresses wrap
    set_config(31, 16, 256, 255, 100, 127, {$urandom, $urandom});
    run_phase(15, 0, 1'b0);

    // single sample, always-match radius, update on every draw
    set_config(1, 1, 256, 1, 64, 64, 64'hFFFF_FFFF_FFFF_FFFF);
    run_phase(4, 30, 1'b1);

    while (items < 1550) begin
      set_config($urandom_range(0, 9) == 0 ? 16 : $urandom_range(1, 16),
                 $urandom_range(1, 4),
                 $urandom_range(0, 9) == 0 ? 256 : $urandom_range(1, 60),
                 $urandom_range(0, 9) == 0 ? 255 : $urandom_range(1, 24),
                 $urandom_range(0, 5) == 0 ? 64 : $urandom_range(3, 20),
                 $urandom_range(0, 5) == 0 ? 3 : $urandom_range(3, 64),
                 {$urandom, $urandom});
      run_phase($urandom_range(1, 10), $urandom_range(20, 70), 1'b1);
    end

    wait_idle();
    $display("covered %0d pixel transfers over %0d register setups", items, phases);
    $display("results: %0d learning, %0d background, %0d foreground", n_learn, n_bg, n_fg);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", pending);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== vibe_background_subtractor.f =====
rtl/vbs_pkg.sv
rtl/vbs_pixel_if.sv
rtl/vbs_result_if.sv
rtl/vbs_mod_unit.sv
rtl/vibe_background_subtractor.sv
tb/vbs_checker.sv
tb/vibe_background_subtractor_test.sv
